@@ hdl/lmps_pkg.sv @@
`timescale 1ns / 1ps
// Package for the LED matrix PWM scanner: field widths, item structs, queue sizing.
// No dependencies.
package lmps_pkg;

  localparam int DEF_MATRIX_COLUMNS = 7;
  localparam int DEF_MATRIX_ROWS    = 7;
  localparam int DEF_LEVEL_BITS     = 8;
  localparam int LEVEL_BITS_MAX     = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [2:0] col_t;
  typedef logic [2:0] row_t;
  typedef logic [7:0] level_t;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    col_t    pixel_column;
    row_t    pixel_row;
    level_t  pixel_level;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  row_drive;
    logic [6:0]  column_select;
    logic [15:0] shift_word;
    col_t        scan_column;
    logic [7:0]  pwm_phase;
  } out_item_t;

  // one queued request after classification
  typedef struct packed {
    logic   is_write;
    col_t   col;
    row_t   row;
    level_t level;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage

@@ hdl/lmps_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, drops out-of-range pixel writes, pushes the rest to the queue.
// Depends on lmps_pkg.
module lmps_front #(
  parameter int MATRIX_COLUMNS = lmps_pkg::DEF_MATRIX_COLUMNS,
  parameter int MATRIX_ROWS    = lmps_pkg::DEF_MATRIX_ROWS
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  lmps_pkg::in_item_t  in_data,
  input  lmps_pkg::qstat_t    q_stat,
  output logic                push,
  output lmps_pkg::qentry_t   push_entry
);

  logic is_write;
  logic in_range;

  assign is_write = (in_data.action == lmps_pkg::ACT_WRITE);
  assign in_range = (32'(in_data.pixel_column) < 32'(MATRIX_COLUMNS)) &&
                    (32'(in_data.pixel_row) < 32'(MATRIX_ROWS));

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full && (!is_write || in_range);

  always_comb begin
    push_entry.is_write = is_write;
    push_entry.col      = in_data.pixel_column;
    push_entry.row      = in_data.pixel_row;
    push_entry.level    = in_data.pixel_level;
  end

endmodule

@@ hdl/lmps_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO between front and back ends.
// Depends on lmps_pkg.
module lmps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lmps_pkg::qentry_t  push_entry,
  input  logic               pop,
  output lmps_pkg::qentry_t  head,
  output lmps_pkg::qstat_t   stat
);

  lmps_pkg::qentry_t mem_r [lmps_pkg::QUEUE_DEPTH];
  logic [lmps_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lmps_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lmps_pkg::QPTR_W:0]   count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == (lmps_pkg::QPTR_W+1)'(lmps_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (lmps_pkg::QPTR_W+1)'(push) - (lmps_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hdl/lmps_back.sv @@
`timescale 1ns / 1ps
// Back end: frame store, PWM compare per row, scan counters and output register.
// Depends on lmps_pkg.
module lmps_back #(
  parameter int MATRIX_COLUMNS = lmps_pkg::DEF_MATRIX_COLUMNS,
  parameter int MATRIX_ROWS    = lmps_pkg::DEF_MATRIX_ROWS,
  parameter int LEVEL_BITS     = lmps_pkg::DEF_LEVEL_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lmps_pkg::qentry_t   head,
  input  lmps_pkg::qstat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lmps_pkg::out_item_t out_data
);

  localparam int CIDX_W = $clog2(MATRIX_COLUMNS);
  localparam int RIDX_W = $clog2(MATRIX_ROWS);

  logic [LEVEL_BITS-1:0] level_r [MATRIX_ROWS][MATRIX_COLUMNS];

  logic [CIDX_W-1:0]     col_r, col_nxt;
  logic [LEVEL_BITS-1:0] phase_r, phase_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lmps_pkg::out_item_t   out_r, out_nxt;

  logic                  out_free;
  logic                  do_write;
  logic                  do_tick;
  logic [CIDX_W-1:0]     wr_col;
  logic [RIDX_W-1:0]     wr_row;
  logic [LEVEL_BITS-1:0] wr_level;
  logic [lmps_pkg::LEVEL_BITS_MAX-1:0] level_ext;
  logic [lmps_pkg::LEVEL_BITS_MAX-1:0] phase_ext;
  logic [7:0]            rows8;
  logic [7:0]            colbyte;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_stat.valid && (head.is_write || out_free);
  assign do_write = pop && head.is_write;
  assign do_tick  = pop && !head.is_write;

  assign wr_col    = head.col[CIDX_W-1:0];
  assign wr_row    = head.row[RIDX_W-1:0];
  assign level_ext = lmps_pkg::LEVEL_BITS_MAX'(head.level);
  assign wr_level  = level_ext[LEVEL_BITS-1:0];
  assign phase_ext = lmps_pkg::LEVEL_BITS_MAX'(phase_r);

  always_comb begin
    rows8 = '0;
    for (int r = 0; r < MATRIX_ROWS; r++) begin
      rows8[MATRIX_ROWS-1-r] = (phase_r < level_r[r][col_r]);
    end
    colbyte = 8'(1) << col_r;
  end

  always_comb begin
    out_nxt.row_drive     = rows8[6:0];
    out_nxt.column_select = colbyte[6:0];
    out_nxt.shift_word    = {~rows8, colbyte};
    out_nxt.scan_column   = lmps_pkg::col_t'(col_r);
    out_nxt.pwm_phase     = phase_ext[7:0];
  end

  always_comb begin
    col_nxt       = col_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (do_tick) begin
      out_valid_nxt = 1'b1;
      if (phase_r == '1) begin
        phase_nxt = '0;
        col_nxt   = (col_r == CIDX_W'(MATRIX_COLUMNS-1)) ? '0 : col_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_r <= out_nxt;
    end
  end

  // frame store: one lane per row, cleared at reset
  for (genvar r = 0; r < MATRIX_ROWS; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int c = 0; c < MATRIX_COLUMNS; c++) begin
          level_r[r][c] <= '0;
        end
      end else if (do_write && wr_row == RIDX_W'(r)) begin
        level_r[r][wr_col] <= wr_level;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/led_matrix_pwm_scanner_core.sv @@
`timescale 1ns / 1ps
// Top level of the LED matrix PWM scanner: front end, request queue, back end.
// A tick request reaches out_valid through the queue, then the output reg; a held out_stall can delay it.
// Throughput: one request per cycle; in_stall rises only when the 4-entry queue is full.
// Reset clears frame store, scan column, PWM phase and the queue.
// Depends on lmps_pkg, lmps_front, lmps_queue, lmps_back.
module led_matrix_pwm_scanner_core #(
  parameter int MATRIX_COLUMNS = lmps_pkg::DEF_MATRIX_COLUMNS,
  parameter int MATRIX_ROWS    = lmps_pkg::DEF_MATRIX_ROWS,
  parameter int LEVEL_BITS     = lmps_pkg::DEF_LEVEL_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lmps_pkg::out_item_t out_data
);

  logic              push;
  logic              pop;
  lmps_pkg::qentry_t push_entry;
  lmps_pkg::qentry_t head;
  lmps_pkg::qstat_t  q_stat;

  lmps_front #(
    .MATRIX_COLUMNS (MATRIX_COLUMNS),
    .MATRIX_ROWS    (MATRIX_ROWS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  lmps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  lmps_back #(
    .MATRIX_COLUMNS (MATRIX_COLUMNS),
    .MATRIX_ROWS    (MATRIX_ROWS),
    .LEVEL_BITS     (LEVEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
